// ===== src/upi_pkg.sv =====
// shared types and constants for the pixel unpremultiply / invert pipeline
package upi_pkg;

	localparam int ChanW = 16;
	localparam int NumChan = 4;
	localparam int NumColor = 3;

	typedef logic [ChanW-1:0] chan_t;
	typedef chan_t [NumChan-1:0] pix_t;

	// divider working set: partial remainder and numerator/quotient shift word
	typedef struct packed {
		chan_t rem;
		chan_t work;
	} div_t;

	typedef div_t [NumColor-1:0] div3_t;

	// per-item side data that rides along the divider stages
	typedef struct packed {
		pix_t               pix;
		logic [NumColor-1:0] sat;
		logic [NumColor-1:0] wide;
	} side_t;

	typedef struct packed {
		logic       depth_is_16;
		logic [1:0] pixel_mode;
		logic [2:0] channel_count;
	} cfg_t;

	localparam logic [1:0] MODE_PASS     = 2'd0;
	localparam logic [1:0] MODE_INVERT   = 2'd1;
	localparam logic [1:0] MODE_UNPREMUL = 2'd2;

	localparam logic [1:0] REG_DEPTH = 2'd0;
	localparam logic [1:0] REG_MODE  = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	localparam chan_t MAX_EIGHT   = 16'h00FF;
	localparam chan_t MAX_SIXTEEN = 16'hFFFF;

	localparam logic [2:0] COUNT_MAX = 3'd4;

endpackage

// ===== src/upi_front.sv =====
// input masking and divider numerator setup (c * max + alpha / 2)
module upi_front import upi_pkg::*; (
	input  pix_t  pix_in,
	input  logic  depth_is_16,
	output pix_t  pix_out,
	output div3_t div_out
);

	chan_t       maxv;
	logic [31:0] prod [NumColor];
	logic [31:0] num [NumColor];

	assign maxv = depth_is_16 ? MAX_SIXTEEN : MAX_EIGHT;

	always_comb begin
		for (int i = 0; i < NumChan; i++) begin
			pix_out[i] = pix_in[i] & maxv;
		end
	end

	// c * 65535 = (c << 16) - c, c * 255 = (c << 8) - c
	always_comb begin
		for (int i = 0; i < NumColor; i++) begin
			if (depth_is_16) begin
				prod[i] = {pix_out[i], 16'h0000} - {16'h0000, pix_out[i]};
			end else begin
				prod[i] = {8'h00, pix_out[i], 8'h00} - {16'h0000, pix_out[i]};
			end
			num[i] = prod[i] + {17'h00000, pix_out[NumChan-1][15:1]};
			div_out[i].rem  = num[i][31:16];
			div_out[i].work = num[i][15:0];
		end
	end

endmodule

// ===== src/upi_div4.sv =====
// four restoring division steps for one channel
module upi_div4 import upi_pkg::*; (
	input  div_t  div_in,
	input  chan_t divisor,
	output div_t  div_out
);

	logic [16:0] r2;
	chan_t       rem;
	chan_t       work;

	always_comb begin
		rem  = div_in.rem;
		work = div_in.work;
		r2   = '0;
		for (int k = 0; k < 4; k++) begin
			r2   = {rem, work[15]};
			work = {work[14:0], 1'b0};
			if (r2 >= {1'b0, divisor}) begin
				r2      = r2 - {1'b0, divisor};
				work[0] = 1'b1;
			end
			rem = r2[15:0];
		end
		div_out.rem  = rem;
		div_out.work = work;
	end

endmodule

// ===== src/upi_select.sv =====
// mode select, saturation, zero alpha and channel count masking
module upi_select import upi_pkg::*; (
	input  side_t side,
	input  div3_t quot,
	input  cfg_t  cfg,
	output pix_t  pix_out
);

	chan_t      maxv;
	pix_t       res;
	logic [2:0] cnt;

	assign maxv = cfg.depth_is_16 ? MAX_SIXTEEN : MAX_EIGHT;
	assign cnt  = (cfg.channel_count > COUNT_MAX) ? COUNT_MAX : cfg.channel_count;

	always_comb begin
		res = side.pix;
		unique case (cfg.pixel_mode)
			MODE_INVERT: begin
				res[0] = maxv - side.pix[0];
			end
			MODE_UNPREMUL: begin
				for (int i = 0; i < NumColor; i++) begin
					if (side.pix[NumChan-1] == '0) begin
						res[i] = '0;
					end else if (side.sat[i]) begin
						res[i] = maxv;
					end else begin
						res[i] = quot[i].work;
					end
				end
			end
			default: begin
				res = side.pix;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < NumChan; i++) begin
			pix_out[i] = (3'(i) < cnt) ? res[i] : '0;
		end
	end

endmodule

// ===== src/pixel_unpremultiply_invert_top.sv =====
// top level: config registers, six-stage pixel pipeline and stream ports
//
//  channel | direction | payload (low bits first)                     | handshake
//  s_      | in        | chan_zero, chan_one, chan_two, chan_alpha    | s_tvalid/s_tready
//  m_      | out       | out_zero, out_one, out_two, out_alpha        | m_tvalid/m_tready
//  cfg_    | in        | depth_is_16, pixel_mode, channel_count       | cfg_we, no wait
//
// one item per cycle unless m_tready stalls; six register stages from accept to m_tvalid
// the 16-bit quotient takes four restoring steps per stage over four stages
// each stage has its own valid bit and a local ready, so bubbles are squeezed out
// and s_tready stays high under a stall until every stage holds an item
// arst_n clears valid bits and config registers (8-bit, pass-through, four channels)
module pixel_unpremultiply_invert_top import upi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // chan_zero, chan_one, chan_two, chan_alpha
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // out_zero, out_one, out_two, out_alpha
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_wdata
);

	// config registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth_is_16   <= 1'b0;
			cfg_q.pixel_mode    <= MODE_PASS;
			cfg_q.channel_count <= COUNT_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEPTH: cfg_q.depth_is_16   <= cfg_wdata[0];
				REG_MODE:  cfg_q.pixel_mode    <= cfg_wdata[1:0];
				REG_COUNT: cfg_q.channel_count <= cfg_wdata;
				default:   cfg_q <= cfg_q;
			endcase
		end
	end

	// valid bits and local readies, stage k loads when empty or draining
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	assign rdy6 = !v_s6 || m_tready;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// stage 1: mask to depth, build numerators
	pix_t  pix_in;
	pix_t  pix_f;
	div3_t div_f;
	pix_t  pix_s1;
	div3_t div_s1;

	assign pix_in = s_tdata;

	upi_front u_front (
		.pix_in      (pix_in),
		.depth_is_16 (cfg_q.depth_is_16),
		.pix_out     (pix_f),
		.div_out     (div_f)
	);

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			pix_s1 <= pix_f;
			div_s1 <= div_f;
		end
	end

	// saturation: quotient above max iff num >= alpha * (max + 1)
	// wide marks num >= alpha << 16, where the 16-step divide would not fit
	side_t side_f;

	always_comb begin
		side_f.pix = pix_s1;
		for (int i = 0; i < NumColor; i++) begin
			side_f.wide[i] = (div_s1[i].rem >= pix_s1[NumChan-1]);
			if (cfg_q.depth_is_16) begin
				side_f.sat[i] = side_f.wide[i];
			end else begin
				side_f.sat[i] = ({div_s1[i].rem[7:0], div_s1[i].work} >=
					{pix_s1[NumChan-1], 8'h00});
			end
		end
	end

	// stages 2 to 5: four quotient bits per stage
	div3_t div_n2, div_n3, div_n4, div_n5;
	div3_t div_s2, div_s3, div_s4, div_s5;
	side_t side_s2, side_s3, side_s4, side_s5;

	for (genvar i = 0; i < NumColor; i++) begin : g_div
		upi_div4 u_div_a (
			.div_in  (div_s1[i]),
			.divisor (pix_s1[NumChan-1]),
			.div_out (div_n2[i])
		);
		upi_div4 u_div_b (
			.div_in  (div_s2[i]),
			.divisor (side_s2.pix[NumChan-1]),
			.div_out (div_n3[i])
		);
		upi_div4 u_div_c (
			.div_in  (div_s3[i]),
			.divisor (side_s3.pix[NumChan-1]),
			.div_out (div_n4[i])
		);
		upi_div4 u_div_d (
			.div_in  (div_s4[i]),
			.divisor (side_s4.pix[NumChan-1]),
			.div_out (div_n5[i])
		);
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			div_s2  <= div_n2;
			side_s2 <= side_f;
		end
		if (rdy3 && v_s2) begin
			div_s3  <= div_n3;
			side_s3 <= side_s2;
		end
		if (rdy4 && v_s3) begin
			div_s4  <= div_n4;
			side_s4 <= side_s3;
		end
		if (rdy5 && v_s4) begin
			div_s5  <= div_n5;
			side_s5 <= side_s4;
		end
	end

	// stage 6: mode select into the output register
	pix_t pix_sel;
	pix_t out_s6;

	upi_select u_select (
		.side    (side_s5),
		.quot    (div_s5),
		.cfg     (cfg_q),
		.pix_out (pix_sel)
	);

	always_ff @(posedge clk) begin
		if (rdy6 && v_s5) begin
			out_s6 <= pix_sel;
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = out_s6;

	// input side only backs up when every stage holds an item
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6))
		else $error("input stalled with an empty stage");

	// a stalled first stage keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy2) |=> (v_s1 && $stable(div_s1) && $stable(pix_s1)))
		else $error("stage 1 item changed under stall");

	// channel 0 partial remainder stays below the divisor when its quotient fits
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && side_s5.pix[NumChan-1] != '0 && !side_s5.wide[0]) |->
		(div_s5[0].rem < side_s5.pix[NumChan-1]))
		else $error("divider remainder out of range");

endmodule

// ===== verif/tb_pixel_unpremultiply_invert_top.sv =====
// testbench for the pixel unpremultiply / invert pipeline: directed and random pixels checked
module tb_pixel_unpremultiply_invert_top;
	import upi_pkg::*;

	// register index the block does not decode, and the mode code it treats as pass-through
	localparam logic [1:0] REG_SPARE  = 2'd3;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam int DRAIN_CYCLES  = 10;   // covers the six pipeline stages plus margin
	localparam int STALL_LIMIT   = 1000; // cycles with no handshake before giving up
	localparam int RANDOM_ITEMS  = 1130;
	localparam int PHASE_ITEMS   = 50;
	localparam int MAX_REPORTS   = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;    // chan_zero, chan_one, chan_two, chan_alpha
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;         // out_zero, out_one, out_two, out_alpha
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [2:0]  cfg_wdata = '0;

	// local copy of the config registers, reset values
	logic       cfg_depth16 = 1'b0;
	logic [1:0] cfg_mode = MODE_PASS;
	logic [2:0] cfg_count = 3'd4;

	pix_t pixels_due[$];          // converted pixels still to come out, oldest first

	int src_max_gap = 8;
	int sink_max_stall = 8;
	int items_sent = 0;
	int results_checked = 0;
	int settings_applied = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	pixel_unpremultiply_invert_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// rounded division of a premultiplied sample by alpha, clipped to the sample maximum
	function automatic chan_t unpremultiply_sample(chan_t c, chan_t alpha, chan_t maxv);
		logic [63:0] num;
		logic [63:0] quo;
		if (alpha == '0) return '0;
		num = 64'(c) * 64'(maxv) + 64'(alpha >> 1);
		quo = num / 64'(alpha);
		return (quo > 64'(maxv)) ? maxv : chan_t'(quo);
	endfunction

	// expected output pixel under the current register copy
	function automatic pix_t convert_pixel(pix_t px);
		chan_t maxv;
		pix_t  ch;
		pix_t  res;
		int    used;
		maxv = cfg_depth16 ? MAX_SIXTEEN : MAX_EIGHT;
		used = (cfg_count > COUNT_MAX) ? int'(COUNT_MAX) : int'(cfg_count);
		for (int i = 0; i < NumChan; i++) begin
			ch[i] = px[i] & maxv;
			res[i] = ch[i];
		end
		case (cfg_mode)
			MODE_INVERT: begin
				res[0] = maxv - ch[0];
			end
			MODE_UNPREMUL: begin
				for (int i = 0; i < NumColor; i++)
					res[i] = unpremultiply_sample(ch[i], ch[NumChan-1], maxv);
			end
			default: ;
		endcase
		// channels past the configured count are forced to zero
		for (int i = 0; i < NumChan; i++)
			if (i >= used) res[i] = '0;
		return res;
	endfunction

	function automatic pix_t make_pixel(chan_t c0, chan_t c1, chan_t c2, chan_t a);
		pix_t p;
		p[0] = c0;
		p[1] = c1;
		p[2] = c2;
		p[3] = a;
		return p;
	endfunction

	// samples biased toward the edges of the range
	function automatic chan_t pick_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return MAX_SIXTEEN;
			2: return chan_t'($urandom_range(0, 3));
			3: return chan_t'($urandom_range(0, 255));
			default: return chan_t'($urandom);
		endcase
	endfunction

	// mostly well-formed premultiplied pixels when un-premultiplying, random otherwise
	function automatic pix_t pick_pixel();
		pix_t  p;
		chan_t lim;
		for (int i = 0; i < NumChan; i++)
			p[i] = pick_sample();
		if (cfg_mode == MODE_UNPREMUL && $urandom_range(0, 3) != 0) begin
			lim = cfg_depth16 ? p[3] : (p[3] & MAX_EIGHT);
			for (int i = 0; i < NumColor; i++) begin
				p[i] = chan_t'($urandom_range(0, int'(lim)));
				// junk in the upper byte must be ignored at 8-bit depth
				if (!cfg_depth16) p[i][15:8] = 8'($urandom);
			end
		end
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s: expected %h, got %h", $time, what, want, got);
	endtask

	// offer one pixel after a random gap and hold it until accepted
	task automatic send_pixel(input pix_t px);
		int gap;
		gap = (src_max_gap == 0) ? 0 : $urandom_range(0, src_max_gap);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		pixels_due.push_back(convert_pixel(px));
		items_sent++;
	endtask

	// stop offering and let every outstanding pixel come out
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// writes all three registers plus the undecoded index, only while the pipe is empty
	task automatic set_config(input logic [2:0] depth_val, input logic [2:0] mode_val,
			input logic [2:0] count_val);
		cfg_we <= 1'b1;
		cfg_index <= REG_DEPTH;
		cfg_wdata <= depth_val;
		@(posedge clk);
		cfg_index <= REG_MODE;
		cfg_wdata <= mode_val;
		@(posedge clk);
		cfg_index <= REG_COUNT;
		cfg_wdata <= count_val;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_wdata <= 3'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_depth16 = depth_val[0];
		cfg_mode = mode_val[1:0];
		cfg_count = count_val;
		settings_applied++;
	endtask

	// reset values: 8-bit, pass-through, four channels
	task automatic test_reset_defaults();
		send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_pixel(make_pixel(16'h1234, 16'h00FF, 16'hABCD, 16'h8000));
		drain_pipeline();
	endtask

	task automatic test_pass_and_invert();
		set_config(3'd1, {1'b0, MODE_PASS}, 3'd4);
		send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_pixel(make_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000));
		drain_pipeline();
		set_config(3'd1, {1'b0, MODE_INVERT}, 3'd4);
		send_pixel(make_pixel(16'h0000, 16'h5555, 16'hAAAA, 16'h0001));
		send_pixel(make_pixel(16'hFFFF, 16'h0001, 16'h0002, 16'hFFFE));
		drain_pipeline();
		// 8-bit invert only looks at the low byte
		set_config(3'd0, {1'b0, MODE_INVERT}, 3'd4);
		send_pixel(make_pixel(16'h1234, 16'hFF00, 16'h00FF, 16'h8081));
		drain_pipeline();
	endtask

	task automatic test_unpremultiply();
		set_config(3'd1, {1'b0, MODE_UNPREMUL}, 3'd4);
		send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000)); // zero alpha
		send_pixel(make_pixel(16'hFFFF, 16'h0000, 16'h7FFF, 16'hFFFF)); // opaque
		send_pixel(make_pixel(16'h0001, 16'h0000, 16'hFFFF, 16'h0001)); // saturation
		send_pixel(make_pixel(16'h8000, 16'h0001, 16'h0002, 16'h0003)); // rounding
		drain_pipeline();
		set_config(3'd0, {1'b0, MODE_UNPREMUL}, 3'd4);
		send_pixel(make_pixel(16'hFF40, 16'hAB80, 16'h0000, 16'h1280));
		send_pixel(make_pixel(16'h0101, 16'h0000, 16'h00FE, 16'hFF00)); // alpha masks to zero
		drain_pipeline();
		// fewer channels still divide by alpha, then trim
		set_config(3'd1, {1'b0, MODE_UNPREMUL}, 3'd3);
		send_pixel(make_pixel(16'h4000, 16'h2000, 16'h1000, 16'h8000));
		drain_pipeline();
		set_config(3'd0, {1'b0, MODE_UNPREMUL}, 3'd1);
		send_pixel(make_pixel(16'h0040, 16'h0020, 16'h0010, 16'h0080));
		drain_pipeline();
	endtask

	// spare mode code, zero count and counts above four
	task automatic test_odd_settings();
		set_config(3'd1, {1'b0, MODE_SPARE}, 3'd4);
		send_pixel(make_pixel(16'h1357, 16'h2468, 16'h9BDF, 16'hFEDC));
		drain_pipeline();
		set_config(3'd1, {1'b0, MODE_PASS}, 3'd0);
		send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		drain_pipeline();
		set_config(3'd0, {1'b0, MODE_INVERT}, 3'd7);
		send_pixel(make_pixel(16'h0010, 16'h0020, 16'h0030, 16'h0040));
		drain_pipeline();
		set_config(3'd1, {1'b0, MODE_UNPREMUL}, 3'd5);
		send_pixel(make_pixel(16'h3000, 16'h6000, 16'h9000, 16'hC000));
		drain_pipeline();
	endtask

	// random settings per phase, with upper write bits exercised as junk
	task automatic test_random_stream();
		int phases;
		logic [1:0] mode;
		logic [2:0] count;
		phases = RANDOM_ITEMS / PHASE_ITEMS;
		for (int ph = 0; ph < phases; ph++) begin
			case ($urandom_range(0, 9))
				0, 1:    mode = MODE_PASS;
				2, 3:    mode = MODE_INVERT;
				4:       mode = MODE_SPARE;
				default: mode = MODE_UNPREMUL;
			endcase
			count = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(1, 4))
			                                    : 3'($urandom_range(0, 7));
			set_config({2'($urandom), 1'(ph % 2)}, {1'($urandom), mode}, count);
			// some phases run with no idling on one or both sides
			src_max_gap = (ph % 3 == 0) ? 0 : 8;
			sink_max_stall = (ph % 4 == 1) ? 0 : 8;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_pixel(pick_pixel());
			drain_pipeline();
		end
	endtask

	// result side: random stall per item, then compare with the oldest prediction
	initial begin : result_sink
		int   stall;
		pix_t got;
		pix_t want;
		string field_name[NumChan];
		field_name = '{"out_zero", "out_one", "out_two", "out_alpha"};
		forever begin
			stall = (sink_max_stall == 0) ? 0 : $urandom_range(0, sink_max_stall);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = m_tdata;
			if (pixels_due.size() == 0) begin
				report_mismatch("pixel with none outstanding", '0, got);
			end else begin
				want = pixels_due.pop_front();
				results_checked++;
				for (int i = 0; i < NumChan; i++)
					if (got[i] !== want[i])
						report_mismatch(field_name[i], 64'(want[i]), 64'(got[i]));
			end
		end
	end

	// watchdog: any cycle without a handshake on either stream counts
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("no handshake for %0d cycles, %0d pixels outstanding",
				idle_cycles, pixels_due.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_pass_and_invert();
		test_unpremultiply();
		test_odd_settings();
		test_random_stream();
		while (pixels_due.size() != 0) begin
			report_mismatch("pixel never produced", 64'(pixels_due.pop_front()), '0);
		end
		$display("run covered %0d pixels, %0d checked, over %0d register settings",
			items_sent, results_checked, settings_applied);
		$display("modes pass, invert, un-premultiply and the spare code at both depths, "
			, "channel counts 0 to 7");
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
